// ===== rtl/dcmr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcmr_pkg: shared types and constants for the ramped H-bridge motor drive
// Command and mode codes, field widths and register reset values.
// ----------------------------------------------------------------------------
package dcmr_pkg;

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned DRIVE_W = 17;
    localparam int unsigned MAG_W   = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [MAG_W-1:0] U_MAX_RESET     = 16'd1023;
    localparam logic [MAG_W-1:0] RAMP_STEP_RESET = 16'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_BRAKE = 3'd2,
        CMD_GO    = 3'd3,
        CMD_TICK  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_INIT  = 3'd0,
        MODE_RUN   = 3'd1,
        MODE_BRAKE = 3'd2,
        MODE_STOP  = 3'd3,
        MODE_DEAD  = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_U_MAX     = 1'd0,
        REG_RAMP_STEP = 1'd1
    } reg_idx_t;

endpackage : dcmr_pkg
`default_nettype wire

// ===== rtl/dc_motor_ramp_controller_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dc_motor_ramp_controller_core: slew-rate limited H-bridge motor drive
// Takes start/stop/brake/go/tick commands, ramps the signed drive toward
// the clamped goal, picks bridge pins at zero drive, reports state per beat.
// ----------------------------------------------------------------------------
// The status of an accepted command beat is registered on the edge that accepts it.
// Throughput: one beat per cycle while the result side is not stalled; the state update is a single 18-bit
//   subtract, compare and add between the state registers.
// Reset (aresetn low, synchronous): mode init, drive, goal, pins and PWM
//   cleared, u_max = 1023, ramp_step = 1, no result pending.
module dc_motor_ramp_controller_core
    import dcmr_pkg::*;
(
    input  wire                    aclk,
    input  wire                    aresetn,
    // command channel
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire  [CMD_W-1:0]       s_cmd,
    input  wire  [DRIVE_W-1:0]     s_target,
    // result channel
    output logic                   m_valid,
    input  wire                    m_ready,
    output logic [MAG_W-1:0]       m_duty,
    output logic                   m_pwm_on,
    output logic                   m_pin_a,
    output logic                   m_pin_b,
    output logic [2:0]             m_mode,
    output logic [DRIVE_W-1:0]     m_drive_now,
    output logic [DRIVE_W-1:0]     m_drive_goal,
    // configuration write channel
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   cfg_index,
    input  wire  [MAG_W-1:0]       cfg_data
);

    // state
    mode_t               mode_reg,   mode_next;
    logic [DRIVE_W-1:0]  drive_reg,  drive_next;
    logic [DRIVE_W-1:0]  goal_reg,   goal_next;
    logic                pin_a_reg,  pin_a_next;
    logic                pin_b_reg,  pin_b_next;
    logic                pwm_reg,    pwm_next;
    logic [MAG_W-1:0]    duty_reg,   duty_next;
    logic                m_valid_reg;
    logic [MAG_W-1:0]    u_max_reg;
    logic [MAG_W-1:0]    ramp_step_reg;

    logic                in_fire;

    // ramp datapath
    logic [DRIVE_W:0]    drive_ext;
    logic [DRIVE_W:0]    diff;
    logic                ramp_up;
    logic [DRIVE_W:0]    gap;
    logic [DRIVE_W:0]    step_ext;
    logic [DRIVE_W:0]    move;
    logic [DRIVE_W:0]    sum;
    logic                drive_zero;
    logic                crossed;
    logic [DRIVE_W-1:0]  tick_drive;

    // go clamp
    logic [DRIVE_W:0]    tgt_ext;
    logic [DRIVE_W:0]    lim_pos;
    logic [DRIVE_W:0]    lim_neg;
    logic [DRIVE_W-1:0]  go_goal;

    logic [DRIVE_W-1:0]  drive_neg;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // tick: move drive toward goal by up to ramp_step, stop at zero on sign flip
    always_comb begin
        drive_ext  = {drive_reg[DRIVE_W-1], drive_reg};
        diff       = {goal_reg[DRIVE_W-1], goal_reg} - drive_ext;
        ramp_up    = !diff[DRIVE_W];
        gap        = ramp_up ? diff : (~diff + 1'b1);
        step_ext   = {{(DRIVE_W+1-MAG_W){1'b0}}, ramp_step_reg};
        move       = (gap > step_ext) ? step_ext : gap;
        sum        = ramp_up ? (drive_ext + move) : (drive_ext - move);
        drive_zero = (drive_reg == '0);
        crossed    = (drive_reg[DRIVE_W-1] && !sum[DRIVE_W] && (sum != '0))
                  || (!drive_reg[DRIVE_W-1] && !drive_zero && sum[DRIVE_W]);
        tick_drive = crossed ? '0 : sum[DRIVE_W-1:0];
    end

    // go: clamp target to +/- u_max
    always_comb begin
        tgt_ext = {s_target[DRIVE_W-1], s_target};
        lim_pos = {{(DRIVE_W+1-MAG_W){1'b0}}, u_max_reg};
        lim_neg = ~lim_pos + 1'b1;
        if ($signed(tgt_ext) > $signed(lim_pos)) begin
            go_goal = lim_pos[DRIVE_W-1:0];
        end else if ($signed(tgt_ext) < $signed(lim_neg)) begin
            go_goal = lim_neg[DRIVE_W-1:0];
        end else begin
            go_goal = s_target;
        end
    end

    // command decode and next state
    always_comb begin
        mode_next  = mode_reg;
        drive_next = drive_reg;
        goal_next  = goal_reg;
        pin_a_next = pin_a_reg;
        pin_b_next = pin_b_reg;
        pwm_next   = pwm_reg;
        unique case (s_cmd)
            CMD_START: begin
                if (mode_reg == MODE_INIT || mode_reg == MODE_DEAD) begin
                    goal_next  = '0;
                    drive_next = '0;
                    pin_a_next = 1'b0;
                    pin_b_next = 1'b0;
                    pwm_next   = 1'b1;
                    mode_next  = MODE_RUN;
                end
            end
            CMD_STOP: begin
                if (mode_reg == MODE_RUN || mode_reg == MODE_BRAKE) begin
                    goal_next = '0;
                    mode_next = MODE_STOP;
                    if (drive_zero) begin
                        drive_next = '0;
                        pin_a_next = 1'b0;
                        pin_b_next = 1'b0;
                        pwm_next   = 1'b0;
                        mode_next  = MODE_DEAD;
                    end
                end
            end
            CMD_BRAKE: begin
                if (mode_reg == MODE_RUN) begin
                    goal_next = '0;
                    mode_next = MODE_BRAKE;
                end
            end
            CMD_GO: begin
                if (mode_reg == MODE_RUN || mode_reg == MODE_BRAKE) begin
                    if (mode_reg == MODE_BRAKE) begin
                        pwm_next = 1'b1;
                    end
                    goal_next = go_goal;
                    mode_next = MODE_RUN;
                end
            end
            CMD_TICK: begin
                if (mode_reg == MODE_RUN || mode_reg == MODE_BRAKE
                        || mode_reg == MODE_STOP) begin
                    // pins only change while the bridge carries no drive
                    if (drive_zero) begin
                        if (!goal_reg[DRIVE_W-1] && goal_reg != '0) begin
                            pin_a_next = 1'b0;
                            pin_b_next = 1'b1;
                        end else if (goal_reg[DRIVE_W-1]) begin
                            pin_a_next = 1'b1;
                            pin_b_next = 1'b0;
                        end else if (mode_reg == MODE_BRAKE) begin
                            pwm_next   = 1'b0;
                            pin_a_next = 1'b1;
                            pin_b_next = 1'b1;
                        end
                    end
                    drive_next = tick_drive;
                    if (mode_reg == MODE_STOP && tick_drive == '0) begin
                        goal_next  = '0;
                        pin_a_next = 1'b0;
                        pin_b_next = 1'b0;
                        pwm_next   = 1'b0;
                        mode_next  = MODE_DEAD;
                    end
                end
            end
            default: begin
                // undefined command codes leave the state alone
            end
        endcase
    end

    // duty is the magnitude of the new drive value
    always_comb begin
        drive_neg = ~drive_next + 1'b1;
        duty_next = drive_next[DRIVE_W-1] ? drive_neg[MAG_W-1:0] : drive_next[MAG_W-1:0];
    end

    // state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_INIT;
            drive_reg   <= '0;
            goal_reg    <= '0;
            pin_a_reg   <= 1'b0;
            pin_b_reg   <= 1'b0;
            pwm_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                mode_reg    <= mode_next;
                drive_reg   <= drive_next;
                goal_reg    <= goal_next;
                pin_a_reg   <= pin_a_next;
                pin_b_reg   <= pin_b_next;
                pwm_reg     <= pwm_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // duty payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            duty_reg <= duty_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_max_reg     <= U_MAX_RESET;
            ramp_step_reg <= RAMP_STEP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_U_MAX:     u_max_reg     <= cfg_data;
                REG_RAMP_STEP: ramp_step_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // result beat mirrors the state after the last command
    assign m_valid      = m_valid_reg;
    assign m_duty       = duty_reg;
    assign m_pwm_on     = pwm_reg;
    assign m_pin_a      = pin_a_reg;
    assign m_pin_b      = pin_b_reg;
    assign m_mode       = mode_reg;
    assign m_drive_now  = drive_reg;
    assign m_drive_goal = goal_reg;

endmodule : dc_motor_ramp_controller_core
`default_nettype wire

// ===== tb/dc_motor_ramp_controller_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dc_motor_ramp_controller_core_tb: self-checking bench for the ramped motor drive
// Drives command beats and register writes, tracks the drive state in a
// behavioral model and checks every status beat field by field. Directed
// corner cases come first, then random command traffic under several
// register settings and sender and receiver stall mixes.
// ----------------------------------------------------------------------------
module dc_motor_ramp_controller_core_tb;
    import dcmr_pkg::*;

    // status of the drive after one command beat
    typedef struct {
        logic [MAG_W-1:0]          duty;
        logic                      pwm_on;
        logic                      pin_a;
        logic                      pin_b;
        logic [2:0]                mode;
        logic signed [DRIVE_W-1:0] drive_now;
        logic signed [DRIVE_W-1:0] drive_goal;
    } drive_status_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    wire                  s_ready;
    logic [CMD_W-1:0]     s_cmd     = CMD_TICK;
    logic [DRIVE_W-1:0]   s_target  = '0;
    wire                  m_valid;
    logic                 m_ready   = 1'b0;
    wire  [MAG_W-1:0]     m_duty;
    wire                  m_pwm_on;
    wire                  m_pin_a;
    wire                  m_pin_b;
    wire  [2:0]           m_mode;
    wire  [DRIVE_W-1:0]   m_drive_now;
    wire  [DRIVE_W-1:0]   m_drive_goal;
    logic                 cfg_valid = 1'b0;
    wire                  cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_U_MAX;
    logic [MAG_W-1:0]     cfg_data  = '0;

    // drive model state
    mode_t            mdl_mode      = MODE_INIT;
    int               mdl_drive     = 0;
    int               mdl_goal      = 0;
    logic             mdl_pin_a     = 1'b0;
    logic             mdl_pin_b     = 1'b0;
    logic             mdl_pwm       = 1'b0;
    logic [MAG_W-1:0] mdl_u_max     = U_MAX_RESET;
    logic [MAG_W-1:0] mdl_ramp_step = RAMP_STEP_RESET;

    drive_status_t due_status[$];
    int            errors        = 0;
    int            src_idle_pct  = 6;
    int            sink_idle_pct = 70;
    int            gen_u_max     = int'(U_MAX_RESET);

    // full-scale, extreme negative code, unit and zero targets
    logic [DRIVE_W-1:0] corner_targets [6] = '{17'h0FFFF, 17'h10000, 17'h10001,
                                               17'h00001, 17'h1FFFF, 17'h00000};

    dc_motor_ramp_controller_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_target     (s_target),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_duty       (m_duty),
        .m_pwm_on     (m_pwm_on),
        .m_pin_a      (m_pin_a),
        .m_pin_b      (m_pin_b),
        .m_mode       (m_mode),
        .m_drive_now  (m_drive_now),
        .m_drive_goal (m_drive_goal),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("[dc_motor_ramp_controller_core] ERROR");
        $finish;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic void shut_drive_off();
        mdl_goal  = 0;
        mdl_drive = 0;
        mdl_pin_a = 1'b0;
        mdl_pin_b = 1'b0;
        mdl_pwm   = 1'b0;
        mdl_mode  = MODE_DEAD;
    endfunction

    // apply one command to the model and queue the status it produces
    function automatic void model_command(input logic [CMD_W-1:0] code,
                                          input logic signed [DRIVE_W-1:0] tgt);
        int            lim;
        int            step;
        int            new_goal;
        int            delta;
        int            nxt;
        drive_status_t st;
        lim  = int'(mdl_u_max);
        step = int'(mdl_ramp_step);
        case (code)
            CMD_START: begin
                if (mdl_mode == MODE_INIT || mdl_mode == MODE_DEAD) begin
                    mdl_goal  = 0;
                    mdl_drive = 0;
                    mdl_pin_a = 1'b0;
                    mdl_pin_b = 1'b0;
                    mdl_pwm   = 1'b1;
                    mdl_mode  = MODE_RUN;
                end
            end
            CMD_STOP: begin
                if (mdl_mode == MODE_RUN || mdl_mode == MODE_BRAKE) begin
                    mdl_goal = 0;
                    mdl_mode = MODE_STOP;
                    if (mdl_drive == 0)
                        shut_drive_off();
                end
            end
            CMD_BRAKE: begin
                if (mdl_mode == MODE_RUN) begin
                    mdl_goal = 0;
                    mdl_mode = MODE_BRAKE;
                end
            end
            CMD_GO: begin
                if (mdl_mode == MODE_RUN || mdl_mode == MODE_BRAKE) begin
                    if (mdl_mode == MODE_BRAKE)
                        mdl_pwm = 1'b1;
                    new_goal = int'(tgt);
                    if (new_goal > lim)
                        new_goal = lim;
                    if (new_goal < -lim)
                        new_goal = -lim;
                    mdl_goal = new_goal;
                    mdl_mode = MODE_RUN;
                end
            end
            CMD_TICK: begin
                if (mdl_mode == MODE_RUN || mdl_mode == MODE_BRAKE || mdl_mode == MODE_STOP) begin
                    // pins only move while the bridge carries no drive
                    if (mdl_drive == 0) begin
                        if (mdl_goal > 0) begin
                            mdl_pin_a = 1'b0;
                            mdl_pin_b = 1'b1;
                        end else if (mdl_goal < 0) begin
                            mdl_pin_a = 1'b1;
                            mdl_pin_b = 1'b0;
                        end else if (mdl_mode == MODE_BRAKE) begin
                            mdl_pwm   = 1'b0;
                            mdl_pin_a = 1'b1;
                            mdl_pin_b = 1'b1;
                        end
                    end
                    // slew-limited step, never crossing zero in one tick
                    if (mdl_drive <= mdl_goal) begin
                        delta = mdl_goal - mdl_drive;
                        if (delta > step)
                            delta = step;
                    end else begin
                        delta = mdl_drive - mdl_goal;
                        if (delta > step)
                            delta = step;
                        delta = -delta;
                    end
                    nxt = mdl_drive + delta;
                    if ((mdl_drive < 0 && nxt > 0) || (mdl_drive > 0 && nxt < 0))
                        nxt = 0;
                    mdl_drive = nxt;
                    if (mdl_mode == MODE_STOP && mdl_drive == 0)
                        shut_drive_off();
                end
            end
            default: ;
        endcase
        st.duty       = MAG_W'(mdl_drive < 0 ? -mdl_drive : mdl_drive);
        st.pwm_on     = mdl_pwm;
        st.pin_a      = mdl_pin_a;
        st.pin_b      = mdl_pin_b;
        st.mode       = mdl_mode;
        st.drive_now  = DRIVE_W'(mdl_drive);
        st.drive_goal = DRIVE_W'(mdl_goal);
        due_status.push_back(st);
    endfunction

    function automatic void compare_field(input string name,
                                          input logic signed [31:0] want,
                                          input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // track accepted beats and register writes, check status beats
    always @(posedge aclk) begin : scoreboard
        drive_status_t want;
        if (!aresetn) begin
            mdl_mode      = MODE_INIT;
            mdl_drive     = 0;
            mdl_goal      = 0;
            mdl_pin_a     = 1'b0;
            mdl_pin_b     = 1'b0;
            mdl_pwm       = 1'b0;
            mdl_u_max     = U_MAX_RESET;
            mdl_ramp_step = RAMP_STEP_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_U_MAX)
                    mdl_u_max = cfg_data;
                else
                    mdl_ramp_step = cfg_data;
            end
            if (s_valid && s_ready)
                model_command(s_cmd, s_target);
            if (m_valid && m_ready) begin
                if (due_status.size() == 0) begin
                    $display("%0t: status beat with none expected, mode %0d drive %0d",
                             $time, m_mode, $signed(m_drive_now));
                    errors++;
                end else begin
                    want = due_status.pop_front();
                    compare_field("duty", want.duty, m_duty);
                    compare_field("pwm_on", want.pwm_on, m_pwm_on);
                    compare_field("pin_a", want.pin_a, m_pin_a);
                    compare_field("pin_b", want.pin_b, m_pin_b);
                    compare_field("mode", want.mode, m_mode);
                    compare_field("drive_now", want.drive_now, $signed(m_drive_now));
                    compare_field("drive_goal", want.drive_goal, $signed(m_drive_goal));
                end
            end
        end
    end

    // one command beat, with optional idle cycles ahead of it
    task automatic send_cmd(input logic [CMD_W-1:0] code, input logic [DRIVE_W-1:0] tgt);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_cmd    <= code;
        s_target <= tgt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop sending and wait for every outstanding status beat
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_status.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [MAG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_config(input logic [MAG_W-1:0] umax, input logic [MAG_W-1:0] step);
        drain_results();
        write_reg(REG_U_MAX, umax);
        write_reg(REG_RAMP_STEP, step);
        cfg_valid <= 1'b0;
        gen_u_max = int'(umax);
    endtask

    // commands before start are all ignored, unknown codes included
    task automatic test_ignored_before_start();
        send_cmd(CMD_TICK, 17'sd0);
        send_cmd(CMD_GO, 17'sd5);
        send_cmd(CMD_W'(int'(CMD_TICK) + 1), 17'h10000);
        send_cmd({CMD_W{1'b1}}, 17'h0FFFF);
        send_cmd(CMD_STOP, 17'sd0);
        send_cmd(CMD_BRAKE, 17'sd0);
    endtask

    // start, repeated start, and a go clamped to the reset u_max
    task automatic test_start_and_clamp();
        send_cmd(CMD_START, 17'sd0);
        send_cmd(CMD_START, 17'sd0);
        send_cmd(CMD_GO, 17'h0FFFF);
        send_cmd(CMD_TICK, 17'sd0);
    endtask

    // full-scale step reverses direction: first tick stops at zero
    task automatic test_sign_change();
        set_config(16'hFFFF, 16'hFFFF);
        send_cmd(CMD_GO, 17'h10000);
        send_cmd(CMD_TICK, 17'sd0);
        send_cmd(CMD_TICK, 17'sd0);
    endtask

    // brake ramps to zero, then engages both pins; go releases it
    task automatic test_brake();
        send_cmd(CMD_BRAKE, 17'sd0);
        send_cmd(CMD_TICK, 17'sd0);
        send_cmd(CMD_TICK, 17'sd0);
        send_cmd(CMD_GO, 17'sd100);
        send_cmd(CMD_TICK, 17'sd0);
    endtask

    // stop ramps down and shuts off; stop at zero drive shuts off at once
    task automatic test_stop();
        send_cmd(CMD_STOP, 17'sd0);
        send_cmd(CMD_TICK, 17'sd0);
        send_cmd(CMD_TICK, 17'sd0);
        send_cmd(CMD_GO, -17'sd20);
        send_cmd(CMD_START, 17'sd0);
        send_cmd(CMD_STOP, 17'sd0);
    endtask

    // zero u_max clamps every goal to zero; zero step freezes the drive
    task automatic test_zero_registers();
        set_config(16'd0, 16'd0);
        send_cmd(CMD_START, 17'sd0);
        send_cmd(CMD_GO, 17'sd500);
        set_config(16'd300, 16'd0);
        send_cmd(CMD_GO, 17'sd500);
        send_cmd(CMD_TICK, 17'sd0);
    endtask

    task automatic send_random_cmd();
        int unsigned        pick;
        int                 mag;
        logic [CMD_W-1:0]   code;
        logic [DRIVE_W-1:0] tgt;
        case ($urandom_range(3))
            0: tgt = DRIVE_W'($urandom);
            1: tgt = DRIVE_W'(int'($urandom_range(0, 2 * gen_u_max)) - gen_u_max);
            2: begin
                mag = gen_u_max + int'($urandom_range(1));
                tgt = DRIVE_W'(($urandom_range(1) != 0) ? mag : -mag);
            end
            default: tgt = corner_targets[$urandom_range(5)];
        endcase
        pick = $urandom_range(99);
        if (pick < 45)
            code = CMD_TICK;
        else if (pick < 67)
            code = CMD_GO;
        else if (pick < 75)
            code = CMD_START;
        else if (pick < 83)
            code = CMD_BRAKE;
        else if (pick < 91)
            code = CMD_STOP;
        else if (pick < 94)
            code = CMD_W'($urandom_range(int'(CMD_TICK) + 1, (1 << CMD_W) - 1));
        else
            code = CMD_TICK;
        send_cmd(code, tgt);
    endtask

    // random traffic in segments, each under its own register setting
    task automatic test_random_traffic();
        logic [MAG_W-1:0] umax;
        logic [MAG_W-1:0] step;
        for (int seg = 0; seg < 12; seg++) begin
            if (seg == 4) begin
                src_idle_pct  = 70;
                sink_idle_pct = 6;
            end else if (seg == 8) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            case (seg)
                0: set_config(16'hFFFF, 16'hFFFF);
                1: set_config(16'd1, 16'd1);
                2: set_config(16'd0, 16'd0);
                3: set_config(16'hFFFF, 16'd1);
                default: begin
                    if ($urandom_range(3) == 0)
                        umax = MAG_W'($urandom_range(1, 255));
                    else
                        umax = MAG_W'($urandom_range(1, 65535));
                    if ($urandom_range(7) == 0)
                        step = 16'hFFFF;
                    else
                        step = MAG_W'($urandom_range(1, int'(umax) / 4 + 1));
                    set_config(umax, step);
                end
            endcase
            repeat (68) send_random_cmd();
        end
    endtask

    initial begin : main
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_ignored_before_start();
        test_start_and_clamp();
        test_sign_change();
        test_brake();
        test_stop();
        test_zero_registers();
        test_random_traffic();
        drain_results();
        repeat (4) @(posedge aclk);
        if (errors == 0)
            $display("[dc_motor_ramp_controller_core] OK");
        else
            $display("[dc_motor_ramp_controller_core] ERROR");
        $finish;
    end

endmodule
